/* rtl/assert_macros.svh */
// assertion helpers included by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define RWH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rwh assertion failed");

// next-cycle implication, checked outside reset
`define RWH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rwh assertion failed");

`endif

/* rtl/rwh_pkg.sv */
package rwh_pkg;

	// result classes
	typedef enum logic [3:0] {
		CLS_HEADER    = 4'd0,
		CLS_ADC_HIGH  = 4'd1,
		CLS_ADC_LOW   = 4'd2,
		CLS_ADC_SKIP  = 4'd3,
		CLS_TDC_LEAD  = 4'd4,
		CLS_TDC_TRAIL = 4'd5,
		CLS_SCALER    = 4'd6,
		CLS_UNKNOWN   = 4'd7,
		CLS_FRAME_ERR = 4'd8,
		CLS_READ      = 4'd9
	} word_class_t;

	// histogram kinds, top bits of the bin address
	typedef enum logic [1:0] {
		KIND_ADC_HIGH  = 2'd0,
		KIND_ADC_LOW   = 2'd1,
		KIND_TDC_LEAD  = 2'd2,
		KIND_TDC_TRAIL = 2'd3
	} hist_kind_t;

	// request commands
	localparam logic CMD_STREAM = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	// data word patterns
	localparam logic [31:0] MASK_ADC      = 32'h0068_0000;
	localparam logic [31:0] PAT_ADC_HIGH  = 32'h0000_0000;
	localparam logic [31:0] PAT_ADC_LOW   = 32'h0008_0000;
	localparam logic [31:0] MASK_TDC      = 32'h0060_1000;
	localparam logic [31:0] PAT_TDC_LEAD  = 32'h0020_1000;
	localparam logic [31:0] PAT_TDC_TRAIL = 32'h0020_0000;
	localparam logic [31:0] MASK_SCALER   = 32'h0060_0000;
	localparam logic [31:0] PAT_SCALER    = 32'h0040_0000;
	localparam int          HEADER_BIT    = 27;
	localparam int          OTR_BIT       = 12;

	// decode result of one request, carried down the pipeline
	typedef struct packed {
		word_class_t cls;
		logic        last;
		logic        bump;
		logic        rd_ok;
	} parse_info_t;

endpackage

/* rtl/rwh_parse.sv */
module rwh_parse #(
	parameter int CHANNELS = 64,
	parameter int BINS     = 4096,
	parameter int CH_W     = 6,
	parameter int BIN_W    = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic                      cmd,
	input  logic [31:0]               word,
	input  logic [1:0]                read_kind,
	input  logic [5:0]                read_channel,
	input  logic [11:0]               read_bin,
	output rwh_pkg::parse_info_t      info,
	output logic [2+CH_W+BIN_W-1:0]   addr
);

	localparam logic [6:0]  CH_LIM  = 7'(CHANNELS);
	localparam logic [12:0] BIN_LIM = 13'(BINS);

	logic               expect_q;
	logic [11:0]        left_q;
	logic               expect_d;
	logic [11:0]        left_d;
	logic [11:0]        left_dec;
	logic [5:0]         w_ch;
	logic [11:0]        w_val;
	logic               otr;
	logic               w_in_range;
	logic               rd_in_range;
	rwh_pkg::hist_kind_t  kind;
	rwh_pkg::word_class_t dcls;
	logic               dbump;

	assign w_ch        = word[18:13];
	assign w_val       = word[11:0];
	assign otr         = word[rwh_pkg::OTR_BIT];
	assign w_in_range  = ({1'b0, w_ch} < CH_LIM) && ({1'b0, w_val} < BIN_LIM);
	assign rd_in_range = ({1'b0, read_channel} < CH_LIM) && ({1'b0, read_bin} < BIN_LIM);
	assign left_dec    = left_q - 12'd1;

	// data word classification, first matching pattern wins
	always_comb begin
		kind  = rwh_pkg::KIND_ADC_HIGH;
		dcls  = rwh_pkg::CLS_UNKNOWN;
		dbump = 1'b0;
		if ((word & rwh_pkg::MASK_ADC) == rwh_pkg::PAT_ADC_HIGH) begin
			kind  = rwh_pkg::KIND_ADC_HIGH;
			dcls  = otr ? rwh_pkg::CLS_ADC_SKIP : rwh_pkg::CLS_ADC_HIGH;
			dbump = !otr;
		end else if ((word & rwh_pkg::MASK_ADC) == rwh_pkg::PAT_ADC_LOW) begin
			kind  = rwh_pkg::KIND_ADC_LOW;
			dcls  = otr ? rwh_pkg::CLS_ADC_SKIP : rwh_pkg::CLS_ADC_LOW;
			dbump = !otr;
		end else if ((word & rwh_pkg::MASK_TDC) == rwh_pkg::PAT_TDC_LEAD) begin
			kind  = rwh_pkg::KIND_TDC_LEAD;
			dcls  = rwh_pkg::CLS_TDC_LEAD;
			dbump = 1'b1;
		end else if ((word & rwh_pkg::MASK_TDC) == rwh_pkg::PAT_TDC_TRAIL) begin
			kind  = rwh_pkg::KIND_TDC_TRAIL;
			dcls  = rwh_pkg::CLS_TDC_TRAIL;
			dbump = 1'b1;
		end else if ((word & rwh_pkg::MASK_SCALER) == rwh_pkg::PAT_SCALER) begin
			dcls  = rwh_pkg::CLS_SCALER;
		end
	end

	// frame tracking and bin address
	always_comb begin
		info       = '{cls: rwh_pkg::CLS_READ, last: 1'b0, bump: 1'b0, rd_ok: rd_in_range};
		expect_d   = expect_q;
		left_d     = left_q;
		addr       = {read_kind, read_channel[CH_W-1:0], read_bin[BIN_W-1:0]};
		case (cmd)
			rwh_pkg::CMD_READ: begin
			end
			rwh_pkg::CMD_STREAM: begin
				info.rd_ok = 1'b0;
				addr       = {kind, w_ch[CH_W-1:0], w_val[BIN_W-1:0]};
				if (expect_q) begin
					if (word[rwh_pkg::HEADER_BIT]) begin
						info.cls  = rwh_pkg::CLS_HEADER;
						left_d    = w_val;
						info.last = (w_val == 12'd0);
						expect_d  = (w_val == 12'd0);
					end else begin
						info.cls  = rwh_pkg::CLS_FRAME_ERR;
					end
				end else begin
					info.cls  = dcls;
					info.bump = dbump && w_in_range;
					left_d    = left_dec;
					info.last = (left_dec == 12'd0);
					expect_d  = (left_dec == 12'd0);
				end
			end
			default: begin
			end
		endcase
	end

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q <= 1'b1;
			left_q   <= 12'd0;
		end else if (accept) begin
			expect_q <= expect_d;
			left_q   <= left_d;
		end
	end

endmodule

/* rtl/rwh_bin_mem.sv */
module rwh_bin_mem #(
	parameter int ADDR_W = 20,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	output logic              clearing
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic              clr_q;
	logic [ADDR_W-1:0] clr_addr_q;

	assign rd_data  = rd_data_q;
	assign clearing = clr_q;

	// zeroing sweep after reset, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == {ADDR_W{1'b1}}) begin
				clr_q <= 1'b0;
			end
		end
	end

	// write port
	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

/* rtl/readout_word_histogrammer.sv */
// a taken request passes the stage 1 register and then the output register to give its result
// throughput: one request per cycle unless in_stall holds it (clearing sweep or out_stall back-pressure),
// with no gap for back-to-back hits on one bin; the bin counts sit in one memory, read at accept and
// written back when stage 1 advances; a write-back register forwards the latest count to the next read of the same bin
// reset: frame state clears at once, then the memory is zeroed one bin a cycle over all
// 4 * 2^CH_W * 2^clog2(BINS) entries (1048576 by default, CH_W at least 1) with in_stall high
`include "assert_macros.svh"

module readout_word_histogrammer #(
	parameter int CHANNELS    = 64,
	parameter int BINS        = 4096,
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [31:0] word,
	input  logic [1:0]  read_kind,
	input  logic [5:0]  read_channel,
	input  logic [11:0] read_bin,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  word_class,
	output logic        frame_last,
	output logic [31:0] bin_count
);

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int BIN_W  = $clog2(BINS);
	localparam int ADDR_W = 2 + CH_W + BIN_W;

	logic                      in_accept;
	logic                      clearing;
	rwh_pkg::parse_info_t      info;
	logic [ADDR_W-1:0]         addr;
	logic                      s1_v;
	rwh_pkg::parse_info_t      info_s1;
	logic [ADDR_W-1:0]         addr_s1;
	logic                      s1_adv;
	logic [COUNT_WIDTH-1:0]    rd_data;
	logic [COUNT_WIDTH-1:0]    old_cnt;
	logic [COUNT_WIDTH-1:0]    new_cnt;
	logic [COUNT_WIDTH+31:0]   cnt_ext;
	logic                      wr_en;
	logic                      fwd_v_q;
	logic [ADDR_W-1:0]         fwd_addr_q;
	logic [COUNT_WIDTH-1:0]    fwd_data_q;
	logic                      out_v_q;
	rwh_pkg::word_class_t      cls_q;
	logic                      last_q;
	logic [31:0]               cnt_q;

	// handshake
	assign s1_adv    = s1_v && (!out_v_q || !out_stall);
	assign in_stall  = clearing || (s1_v && !s1_adv);
	assign in_accept = in_valid && !in_stall;

	rwh_parse #(
		.CHANNELS (CHANNELS),
		.BINS     (BINS),
		.CH_W     (CH_W),
		.BIN_W    (BIN_W)
	) u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_accept),
		.cmd          (cmd),
		.word         (word),
		.read_kind    (read_kind),
		.read_channel (read_channel),
		.read_bin     (read_bin),
		.info         (info),
		.addr         (addr)
	);

	rwh_bin_mem #(
		.ADDR_W (ADDR_W),
		.DATA_W (COUNT_WIDTH)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (in_accept),
		.rd_addr  (addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (addr_s1),
		.wr_data  (new_cnt),
		.clearing (clearing)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (in_accept) begin
			s1_v <= 1'b1;
		end else if (s1_adv) begin
			s1_v <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			info_s1 <= info;
			addr_s1 <= addr;
		end
	end

	// count with forwarding from the last write-back, saturating increment
	assign old_cnt = (fwd_v_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : rd_data;
	assign new_cnt = (old_cnt == {COUNT_WIDTH{1'b1}}) ? old_cnt : old_cnt + 1'b1;
	assign wr_en   = s1_adv && info_s1.bump;
	assign cnt_ext = {32'd0, old_cnt};

	// write-back forwarding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
		end else if (wr_en) begin
			fwd_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= new_cnt;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_adv) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			cls_q  <= info_s1.cls;
			last_q <= info_s1.last;
			cnt_q  <= (info_s1.cls == rwh_pkg::CLS_READ && info_s1.rd_ok) ?
				cnt_ext[31:0] : 32'd0;
		end
	end

	assign out_valid  = out_v_q;
	assign word_class = cls_q;
	assign frame_last = last_q;
	assign bin_count  = cnt_q;

	// checks
	`RWH_ASSERT_IMP(a_no_write_in_clear, clk, arst_n, wr_en, !clearing)
	`RWH_ASSERT_IMP(a_count_no_wrap, clk, arst_n, wr_en, new_cnt != '0)
	`RWH_ASSERT_IMP(a_count_only_on_read, clk, arst_n,
		out_v_q && cls_q != rwh_pkg::CLS_READ, cnt_q == 32'd0)
	`RWH_ASSERT_IMP(a_last_class, clk, arst_n, out_v_q && last_q,
		cls_q != rwh_pkg::CLS_READ && cls_q != rwh_pkg::CLS_FRAME_ERR)
	`RWH_ASSERT_NXT(a_fwd_tracks_write, clk, arst_n, wr_en,
		fwd_v_q && fwd_addr_q == $past(addr_s1))

endmodule
